/* hw/rtl/bsbc_pkg.sv */
// Boot stream block checker: shared types and constants.
// Used by bsbc_walker and boot_stream_block_checker_core; no dependencies.
`timescale 1ns / 1ps

package bsbc_pkg;

	localparam int unsigned HEADER_BYTES  = 16;
	localparam int unsigned FINAL_BIT     = 7;
	localparam int unsigned FILL_BIT      = 0;
	localparam int unsigned PAYLOAD_ALIGN = 4;
	localparam int unsigned LEN_FIRST     = 8;
	localparam int unsigned FLAG_POS      = 1;

	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_UNALIGNED  = 2'd1;
	localparam logic [1:0] STATUS_LEN_MISMATCH = 2'd2;
	localparam logic [1:0] STATUS_NOT_FINAL  = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [32:0] block_size;
		logic [31:0] block_number;
		logic        stream_end;
		logic [1:0]  status;
	} result_t;

endpackage

/* hw/rtl/bsbc_walker.sv */
// Block header walker: holds per-stream state, results at block and stream ends.
// Depends on bsbc_pkg.
`timescale 1ns / 1ps

module bsbc_walker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  bsbc_pkg::item_t  item,
	output logic             res_valid,
	output bsbc_pkg::result_t res
);

	localparam logic [4:0] HdrEnd   = 5'(bsbc_pkg::HEADER_BYTES);
	localparam logic [4:0] LastHdr  = 5'(bsbc_pkg::HEADER_BYTES - 1);
	localparam logic [4:0] FlagPos  = 5'(bsbc_pkg::FLAG_POS);
	localparam logic [2:0] LenGroup = 3'(bsbc_pkg::LEN_FIRST / 4);
	localparam logic [1:0] AlignMask = 2'(bsbc_pkg::PAYLOAD_ALIGN - 1);

	logic [4:0]  header_pos_q;
	logic        fill_mark_q;
	logic        final_mark_q;
	logic [31:0] payload_length_q;
	logic [31:0] payload_left_q;
	logic [31:0] blocks_done_q;
	logic [1:0]  error_code_q;

	logic [4:0]  pos_n;
	logic        fill_n;
	logic        final_n;
	logic [31:0] len_n;
	logic [31:0] left_n;
	logic [31:0] blocks_n;
	logic [1:0]  err_n;
	logic        ended;
	logic [32:0] size;
	logic [1:0]  status;

	always_comb begin
		pos_n    = header_pos_q;
		fill_n   = fill_mark_q;
		final_n  = final_mark_q;
		len_n    = payload_length_q;
		left_n   = payload_left_q;
		blocks_n = blocks_done_q;
		err_n    = error_code_q;
		ended    = 1'b0;
		size     = '0;
		if (error_code_q == bsbc_pkg::STATUS_OK) begin
			if (header_pos_q < HdrEnd) begin
				if (header_pos_q == '0) begin
					len_n = '0;
				end
				if (header_pos_q == FlagPos) begin
					fill_n  = item.data_byte[bsbc_pkg::FILL_BIT];
					final_n = item.data_byte[bsbc_pkg::FINAL_BIT];
				end
				if (header_pos_q[4:2] == LenGroup) begin
					unique case (header_pos_q[1:0])
						2'd0: len_n[7:0]   = len_n[7:0]   | item.data_byte;
						2'd1: len_n[15:8]  = len_n[15:8]  | item.data_byte;
						2'd2: len_n[23:16] = len_n[23:16] | item.data_byte;
						default: len_n[31:24] = len_n[31:24] | item.data_byte;
					endcase
				end
				pos_n = header_pos_q + 5'd1;
				if (header_pos_q == LastHdr) begin
					if (fill_n) begin
						len_n = '0;
					end
					if ((len_n[1:0] & AlignMask) != 2'd0) begin
						err_n = bsbc_pkg::STATUS_UNALIGNED;
					end else if (len_n == '0) begin
						ended = 1'b1;
					end else begin
						left_n = len_n;
					end
				end
			end else begin
				if (payload_left_q != '0) begin
					left_n = payload_left_q - 32'd1;
				end
				if (left_n == '0) begin
					ended = 1'b1;
				end
			end
			if (ended) begin
				blocks_n = blocks_done_q + 32'd1;
				size     = 33'(bsbc_pkg::HEADER_BYTES) + {1'b0, len_n};
				pos_n    = '0;
			end
		end

		if (err_n != bsbc_pkg::STATUS_OK) begin
			status = err_n;
		end else if (ended) begin
			status = final_n ? bsbc_pkg::STATUS_OK : bsbc_pkg::STATUS_NOT_FINAL;
		end else begin
			status = bsbc_pkg::STATUS_LEN_MISMATCH;
		end

		res_valid        = step && (ended || item.last_byte);
		res.block_size   = size;
		res.block_number = blocks_n;
		res.stream_end   = item.last_byte;
		res.status       = item.last_byte ? status : bsbc_pkg::STATUS_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_pos_q     <= '0;
			fill_mark_q      <= 1'b0;
			final_mark_q     <= 1'b0;
			payload_length_q <= '0;
			payload_left_q   <= '0;
			blocks_done_q    <= '0;
			error_code_q     <= bsbc_pkg::STATUS_OK;
		end else if (step) begin
			if (item.last_byte) begin
				header_pos_q     <= '0;
				fill_mark_q      <= 1'b0;
				final_mark_q     <= 1'b0;
				payload_length_q <= '0;
				payload_left_q   <= '0;
				blocks_done_q    <= '0;
				error_code_q     <= bsbc_pkg::STATUS_OK;
			end else begin
				header_pos_q     <= pos_n;
				fill_mark_q      <= fill_n;
				final_mark_q     <= final_n;
				payload_length_q <= len_n;
				payload_left_q   <= left_n;
				blocks_done_q    <= blocks_n;
				error_code_q     <= err_n;
			end
		end
	end

endmodule

/* hw/rtl/boot_stream_block_checker_core.sv */
// Boot stream block checker top level: input register, walker, result register.
// Depends on bsbc_pkg and bsbc_walker.
//
//   channel  | direction | handshake                  | payload
//   item     | in        | item_valid / item_ready     | bsbc_pkg::item_t
//   result   | out       | result_valid / result_ready | bsbc_pkg::result_t
//
// One byte per cycle while results are taken; a result passes the input and result registers.
// The walker updates its state in the cycle a registered byte moves on to the result register.
// A byte waits in the input register only while a result is held and not taken.
// Reset clears the stream state; a new stream starts after each last byte.
`timescale 1ns / 1ps

module boot_stream_block_checker_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  bsbc_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output bsbc_pkg::result_t result
);

	logic              valid_s1;
	bsbc_pkg::item_t   item_s1;
	logic              advance;
	logic              res_valid;
	bsbc_pkg::result_t res;
	logic              result_valid_q;
	bsbc_pkg::result_t result_q;

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	bsbc_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= res_valid;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.stream_end |-> result.status == bsbc_pkg::STATUS_OK)
		else $error("nonzero status on a block result");

	a_block_has_size: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.stream_end |-> result.block_size != '0)
		else $error("block result with zero size");

	a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1 && result_valid && !result_ready)
		else $error("input stalled without a held result");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");
`endif

endmodule

/* dv/bsbc_block_tracker.sv */
// Watches both channels of boot_stream_block_checker_core, walks the byte stream itself
// and compares every block and stream report against its own prediction.
// Depends on bsbc_pkg.
`timescale 1ns / 1ps

module bsbc_block_tracker
	import bsbc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result,
	output int      fails,
	output int      pending
);

	logic [4:0]  hdr_pos;
	logic        fill_flag;
	logic        final_flag;
	logic [31:0] pay_len;
	logic [31:0] pay_left;
	logic [31:0] blk_count;
	logic [1:0]  err;
	result_t     reports_due [$];

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		fails++;
	endtask

	task automatic clear_walk();
		hdr_pos    = '0;
		fill_flag  = 1'b0;
		final_flag = 1'b0;
		pay_len    = '0;
		pay_left   = '0;
		blk_count  = '0;
		err        = STATUS_OK;
	endtask

	task automatic walk_byte(input item_t it);
		logic        ended;
		logic [32:0] size;
		result_t     r;
		ended = 1'b0;
		size  = '0;
		if (err == STATUS_OK) begin
			if (hdr_pos < HEADER_BYTES) begin
				if (hdr_pos == 0)
					pay_len = '0;
				if (hdr_pos == FLAG_POS) begin
					fill_flag  = it.data_byte[FILL_BIT];
					final_flag = it.data_byte[FINAL_BIT];
				end
				if (hdr_pos >= LEN_FIRST && hdr_pos <= LEN_FIRST + 3)
					pay_len = pay_len | ({24'd0, it.data_byte} << (8 * (hdr_pos - LEN_FIRST)));
				hdr_pos = hdr_pos + 1'b1;
				if (hdr_pos == HEADER_BYTES) begin
					if (fill_flag)
						pay_len = '0;
					if (pay_len % PAYLOAD_ALIGN != 0)
						err = STATUS_UNALIGNED;
					else if (pay_len == 0)
						ended = 1'b1;
					else
						pay_left = pay_len;
				end
			end else begin
				if (pay_left != 0)
					pay_left = pay_left - 1'b1;
				if (pay_left == 0)
					ended = 1'b1;
			end
			if (ended) begin
				blk_count = blk_count + 1'b1;
				size      = 33'(HEADER_BYTES) + {1'b0, pay_len};
				hdr_pos   = '0;
			end
		end
		r.block_size   = size;
		r.block_number = blk_count;
		r.stream_end   = it.last_byte;
		r.status       = STATUS_OK;
		if (it.last_byte) begin
			if (err != STATUS_OK)
				r.status = err;
			else if (ended)
				r.status = final_flag ? STATUS_OK : STATUS_NOT_FINAL;
			else
				r.status = STATUS_LEN_MISMATCH;
			reports_due.insert(reports_due.size(), r);
			clear_walk();
		end else if (ended) begin
			reports_due.insert(reports_due.size(), r);
		end
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (reports_due.size() == 0) begin
			report($sformatf("result with nothing expected: %h", got));
		end else begin
			want = reports_due.pop_front();
			if (got.block_size !== want.block_size)
				report($sformatf("block_size got %0h expected %0h",
					got.block_size, want.block_size));
			if (got.block_number !== want.block_number)
				report($sformatf("block_number got %0h expected %0h",
					got.block_number, want.block_number));
			if (got.stream_end !== want.stream_end)
				report($sformatf("stream_end got %b expected %b",
					got.stream_end, want.stream_end));
			if (got.status !== want.status)
				report($sformatf("status got %0d expected %0d", got.status, want.status));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_walk();
			reports_due.delete();
			fails = 0;
			pending <= 0;
		end else begin
			if (item_valid && item_ready)
				walk_byte(item);
			if (result_valid && result_ready)
				check_result(result);
			pending <= reports_due.size();
		end
	end

endmodule

/* dv/boot_stream_block_checker_core_tb.sv */
// Top of the boot_stream_block_checker_core testbench: clock, reset, byte stream stimulus,
// random receiver stalls and the verdict. Depends on bsbc_pkg, bsbc_block_tracker and the core.
`timescale 1ns / 1ps

module boot_stream_block_checker_core_tb;

	import bsbc_pkg::*;

	localparam int TOTAL_BYTES = 1550;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	int      fails;
	int      pending;

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          bytes_sent = 0;
	logic [7:0]  stream_bytes [$];

	boot_stream_block_checker_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	bsbc_block_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fails        (fails),
		.pending      (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ready <= 1'b0;
		else
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{data_byte: b, last_byte: last};
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_stream();
		foreach (stream_bytes[i])
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
	endtask

	// a few blocks with random content; some unaligned, oversized, cut short or overrun
	task automatic make_stream();
		int          nblk;
		int          kind;
		int          pay_cnt;
		int          keep;
		logic [31:0] plen;
		logic [7:0]  hdr [16];
		logic        fill;
		logic        fin;
		logic        stop;
		stream_bytes.delete();
		nblk = $urandom_range(1, 4);
		stop = 1'b0;
		for (int k = 0; k < nblk && !stop; k++) begin
			kind = $urandom_range(99);
			fill = (kind < 10);
			fin  = (k == nblk - 1) ? ($urandom_range(99) < 85) : 1'($urandom_range(1));
			if (kind < 20) begin
				plen    = '0;
				pay_cnt = 0;
			end else if (kind < 82) begin
				plen    = 4 * $urandom_range(1, 12);
				pay_cnt = plen;
			end else if (kind < 92) begin
				plen    = 4 * $urandom_range(0, 12) + $urandom_range(1, 3);
				pay_cnt = $urandom_range(0, 6);
				stop    = 1'b1;
			end else begin
				plen    = ($urandom() | 32'h0001_0000) & ~32'd3;
				pay_cnt = $urandom_range(0, 20);
				stop    = 1'b1;
			end
			for (int i = 0; i < 16; i++)
				hdr[i] = 8'($urandom_range(255));
			hdr[FLAG_POS][FILL_BIT]  = fill;
			hdr[FLAG_POS][FINAL_BIT] = fin;
			if (!fill)
				for (int i = 0; i < 4; i++)
					hdr[LEN_FIRST + i] = plen[8 * i +: 8];
			for (int i = 0; i < 16; i++)
				stream_bytes.insert(stream_bytes.size(), hdr[i]);
			for (int i = 0; i < pay_cnt; i++)
				stream_bytes.insert(stream_bytes.size(), 8'($urandom_range(255)));
		end
		kind = $urandom_range(99);
		if (kind < 12 && stream_bytes.size() > 1) begin
			keep = $urandom_range(1, stream_bytes.size() - 1);
			while (stream_bytes.size() > keep)
				void'(stream_bytes.pop_back());
		end else if (kind < 22) begin
			keep = $urandom_range(1, 20);
			for (int i = 0; i < keep; i++)
				stream_bytes.insert(stream_bytes.size(), 8'($urandom_range(255)));
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unaligned length found on the last byte, then a one-byte truncated header
		send_idle_pct = 12;
		recv_idle_pct = 62;
		stream_bytes = {8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_stream();
		stream_bytes = {8'hFF};
		send_stream();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 62 : 0;
			recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 12 : 0;
			while (bytes_sent < (ph + 1) * TOTAL_BYTES / 3) begin
				make_stream();
				send_stream();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
